// ===== src/rcmc_pkg.sv =====
// Shared types, codes and helpers for the random contraction minimum cut block.
// Used by the controller, the datapath, the top level and the checker.
package rcmc_pkg;

	localparam int NODE_W = 6;
	localparam int PICK_W = 10;
	localparam int CNT_W = 7;
	localparam int CUT_W = 11;

	localparam logic [CNT_W-1:0] MIN_NODES = 7'd2;
	localparam logic [CNT_W-1:0] STOP_SETS = 7'd2;
	localparam logic [CNT_W-1:0] NODES_RESET = 7'd64;
	localparam logic [CUT_W-1:0] CUT_MAX = 11'h7FF;

	typedef enum logic [1:0] {
		FN_ADD      = 2'd0,
		FN_CONTRACT = 2'd1,
		FN_REPORT   = 2'd2,
		FN_CLEAR    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		RS_OK   = 2'd0,
		RS_FULL = 2'd1,
		RS_BAD  = 2'd2,
		RS_TWO  = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [NODE_W-1:0]  end_a;
		logic [NODE_W-1:0]  end_b;
		logic [PICK_W-1:0]  edge_pick;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [NODE_W-1:0]  node_index;
		logic [NODE_W-1:0]  node_label;
		logic [CNT_W-1:0]   sets_left;
		logic [CUT_W-1:0]   cut_edges;
		logic               last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CT_EDGE,
		S_CT_LAB,
		S_SWEEP,
		S_WALK,
		S_OUT_RD,
		S_OUT_LD,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic take;
		logic cfg_write;
		logic do_add;
		logic do_clear;
		logic chk_contract;
		logic chk_ends;
		logic merge_start;
		logic sweep;
		logic walk_start;
		logic walk;
		logic out_start;
		logic out_read;
		logic load_node;
		logic load_single;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  ct_reject;
		logic  ends_bad;
		logic  same_set;
		logic  sweep_done;
		logic  walk_done;
		logic  out_free;
		logic  out_last;
	} dp_sts_t;

	// Node count in use: the register value held within two and the node capacity.
	function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] top);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < MIN_NODES) r = MIN_NODES;
		else if (v > top) r = top;
		return r;
	endfunction

endpackage

// ===== src/rcmc_ctrl.sv =====
// Sequencing state machine for the minimum cut block.
// Depends on rcmc_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module rcmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  rcmc_pkg::dp_sts_t sts,
	output rcmc_pkg::dp_cmd_t ctl
);

	rcmc_pkg::state_t state_q, state_d;
	logic idle;

	assign idle = (state_q == rcmc_pkg::S_IDLE);
	assign cmd_stall = !idle;
	assign cfg_ready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcmc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcmc_pkg::S_IDLE: begin
				if (cmd_valid) state_d = rcmc_pkg::S_DECODE;
			end
			rcmc_pkg::S_DECODE: begin
				unique case (sts.func)
					rcmc_pkg::FN_ADD:      state_d = rcmc_pkg::S_FINISH;
					rcmc_pkg::FN_CONTRACT: state_d = sts.ct_reject ? rcmc_pkg::S_FINISH
					                                               : rcmc_pkg::S_CT_EDGE;
					rcmc_pkg::FN_REPORT:   state_d = rcmc_pkg::S_WALK;
					rcmc_pkg::FN_CLEAR:    state_d = rcmc_pkg::S_FINISH;
					default:               state_d = rcmc_pkg::S_FINISH;
				endcase
			end
			rcmc_pkg::S_CT_EDGE: begin
				state_d = sts.ends_bad ? rcmc_pkg::S_FINISH : rcmc_pkg::S_CT_LAB;
			end
			rcmc_pkg::S_CT_LAB: begin
				state_d = sts.same_set ? rcmc_pkg::S_FINISH : rcmc_pkg::S_SWEEP;
			end
			rcmc_pkg::S_SWEEP: begin
				if (sts.sweep_done) state_d = rcmc_pkg::S_FINISH;
			end
			rcmc_pkg::S_WALK: begin
				if (sts.walk_done) state_d = rcmc_pkg::S_OUT_RD;
			end
			rcmc_pkg::S_OUT_RD: begin
				state_d = rcmc_pkg::S_OUT_LD;
			end
			rcmc_pkg::S_OUT_LD: begin
				if (sts.out_free) begin
					state_d = sts.out_last ? rcmc_pkg::S_IDLE : rcmc_pkg::S_OUT_RD;
				end
			end
			rcmc_pkg::S_FINISH: begin
				if (sts.out_free) state_d = rcmc_pkg::S_IDLE;
			end
			default: state_d = rcmc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			rcmc_pkg::S_IDLE: begin
				ctl.take = cmd_valid;
				ctl.cfg_write = cfg_valid;
			end
			rcmc_pkg::S_DECODE: begin
				unique case (sts.func)
					rcmc_pkg::FN_ADD:      ctl.do_add = 1'b1;
					rcmc_pkg::FN_CONTRACT: ctl.chk_contract = 1'b1;
					rcmc_pkg::FN_REPORT:   ctl.walk_start = 1'b1;
					rcmc_pkg::FN_CLEAR:    ctl.do_clear = 1'b1;
					default:               ctl.do_clear = 1'b0;
				endcase
			end
			rcmc_pkg::S_CT_EDGE: ctl.chk_ends = 1'b1;
			rcmc_pkg::S_CT_LAB:  ctl.merge_start = !sts.same_set;
			rcmc_pkg::S_SWEEP:   ctl.sweep = 1'b1;
			rcmc_pkg::S_WALK: begin
				ctl.walk = 1'b1;
				ctl.out_start = sts.walk_done;
			end
			rcmc_pkg::S_OUT_RD:  ctl.out_read = 1'b1;
			rcmc_pkg::S_OUT_LD:  ctl.load_node = sts.out_free;
			rcmc_pkg::S_FINISH:  ctl.load_single = sts.out_free;
			default:             ctl = '0;
		endcase
	end

endmodule

// ===== src/rcmc_datapath.sv =====
// Datapath of the minimum cut block: edge store, label store, counters and result register.
// Depends on rcmc_pkg; all sequencing comes from rcmc_ctrl through dp_cmd_t.
module rcmc_datapath #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcmc_pkg::dp_cmd_t             ctl,
	output rcmc_pkg::dp_sts_t             sts,
	input  rcmc_pkg::req_t                cmd,
	input  logic [rcmc_pkg::CNT_W-1:0]    cfg_data,
	output rcmc_pkg::rsp_t                res,
	output logic                          res_valid,
	input  logic                          res_stall
);

	localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW = $clog2(MAX_EDGES + 1);
	localparam int PW = (ETW > rcmc_pkg::PICK_W) ? ETW : rcmc_pkg::PICK_W;
	localparam int NW = rcmc_pkg::NODE_W;
	localparam int CW = rcmc_pkg::CNT_W;
	localparam logic [CW-1:0] NODE_CAP = CW'(MAX_NODES);
	localparam logic [ETW-1:0] EDGE_CAP = ETW'(MAX_EDGES);

	rcmc_pkg::req_t    req_q;
	rcmc_pkg::status_t status_q;
	rcmc_pkg::rsp_t    res_q;
	logic              res_valid_q;

	logic [CW-1:0]   nodes_q, set_total_q, node_q, n;
	logic [ETW-1:0]  edge_total_q, edge_q;
	logic [NW-1:0]   lo_q, hi_q;
	logic [rcmc_pkg::CUT_W-1:0] cut_q;

	logic            sw_v_s1, wk_v_s1, wk_v_s2;
	logic [NAW-1:0]  sw_addr_s1;

	logic [2*NW-1:0] edge_mem [MAX_EDGES];
	logic [2*NW-1:0] edge_rd_q;
	logic [NW-1:0]   lab_mem [MAX_NODES];
	logic [MAX_NODES-1:0] lab_ok_q;
	logic [NW-1:0]   a_data_q, b_data_q;
	logic            a_ok_q, b_ok_q;
	logic [NAW-1:0]  a_addr_q, b_addr_q;

	rcmc_pkg::status_t add_status, ct_status;
	logic [NW-1:0]   u_st, v_st, label_a, label_b;
	logic            ends_in, sweep_issue, wk_issue, wk_hit2, lab_rd, lab_we;
	logic            e_re, add_ok, ct_go, relabel;
	logic [NAW-1:0]  a_addr, b_addr;
	logic [EAW-1:0]  e_addr;

	assign n = rcmc_pkg::clamp_nodes(nodes_q, NODE_CAP);
	assign u_st = edge_rd_q[NW-1:0];
	assign v_st = edge_rd_q[2*NW-1:NW];
	assign ends_in = ({1'b0, u_st} < n) && ({1'b0, v_st} < n);

	// An entry never written since the last relabel still holds its own index.
	assign label_a = a_ok_q ? a_data_q : NW'(a_addr_q);
	assign label_b = b_ok_q ? b_data_q : NW'(b_addr_q);

	always_comb begin
		if (({1'b0, req_q.end_a} >= n) || ({1'b0, req_q.end_b} >= n)) begin
			add_status = rcmc_pkg::RS_BAD;
		end else if (edge_total_q == EDGE_CAP) begin
			add_status = rcmc_pkg::RS_FULL;
		end else begin
			add_status = rcmc_pkg::RS_OK;
		end
	end

	always_comb begin
		if (set_total_q <= rcmc_pkg::STOP_SETS) begin
			ct_status = rcmc_pkg::RS_TWO;
		end else if (PW'(req_q.edge_pick) >= PW'(edge_total_q)) begin
			ct_status = rcmc_pkg::RS_BAD;
		end else begin
			ct_status = rcmc_pkg::RS_OK;
		end
	end

	assign add_ok = ctl.do_add && (add_status == rcmc_pkg::RS_OK);
	assign ct_go = ctl.chk_contract && (ct_status == rcmc_pkg::RS_OK);
	assign relabel = ctl.do_clear || ctl.cfg_write;

	assign sweep_issue = ctl.sweep && (node_q < n);
	assign wk_issue = ctl.walk && (edge_q < edge_total_q);
	assign wk_hit2 = wk_v_s1 && ends_in;

	assign e_re = ct_go || wk_issue;
	assign e_addr = ct_go ? EAW'(req_q.edge_pick) : edge_q[EAW-1:0];

	// Both label ports follow the stored endpoints during a contraction check or a walk;
	// otherwise port A steps through the nodes.
	always_comb begin
		lab_rd = 1'b1;
		a_addr = node_q[NAW-1:0];
		b_addr = v_st[NAW-1:0];
		if (ctl.chk_ends || wk_hit2) begin
			a_addr = u_st[NAW-1:0];
		end else if (!(sweep_issue || ctl.out_read)) begin
			lab_rd = 1'b0;
		end
	end

	assign lab_we = sw_v_s1 && (label_a == hi_q);

	always_ff @(posedge clk) begin
		if (add_ok) edge_mem[edge_total_q[EAW-1:0]] <= {req_q.end_b, req_q.end_a};
		if (e_re) edge_rd_q <= edge_mem[e_addr];
		if (lab_we) lab_mem[sw_addr_s1] <= lo_q;
		if (lab_rd) begin
			a_data_q <= lab_mem[a_addr];
			a_ok_q <= lab_ok_q[a_addr];
			a_addr_q <= a_addr;
			b_data_q <= lab_mem[b_addr];
			b_ok_q <= lab_ok_q[b_addr];
			b_addr_q <= b_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lab_ok_q <= '0;
		end else if (relabel) begin
			lab_ok_q <= '0;
		end else if (lab_we) begin
			lab_ok_q[sw_addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) req_q <= cmd;
		if (ctl.merge_start) begin
			lo_q <= (label_a < label_b) ? label_a : label_b;
			hi_q <= (label_a < label_b) ? label_b : label_a;
		end
		sw_addr_s1 <= node_q[NAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= rcmc_pkg::NODES_RESET;
			set_total_q <= NODE_CAP;
			edge_total_q <= '0;
			status_q <= rcmc_pkg::RS_OK;
			node_q <= '0;
			edge_q <= '0;
			cut_q <= '0;
			sw_v_s1 <= 1'b0;
			wk_v_s1 <= 1'b0;
			wk_v_s2 <= 1'b0;
		end else begin
			sw_v_s1 <= sweep_issue;
			wk_v_s1 <= wk_issue;
			wk_v_s2 <= wk_hit2;

			if (ctl.cfg_write) begin
				nodes_q <= cfg_data;
				set_total_q <= rcmc_pkg::clamp_nodes(cfg_data, NODE_CAP);
			end else if (ctl.do_clear) begin
				set_total_q <= n;
			end else if (ctl.merge_start) begin
				set_total_q <= set_total_q - 1'b1;
			end

			if (ctl.do_clear) edge_total_q <= '0;
			else if (add_ok) edge_total_q <= edge_total_q + 1'b1;

			if (ctl.take) status_q <= rcmc_pkg::RS_OK;
			else if (ctl.do_add) status_q <= add_status;
			else if (ctl.chk_contract) status_q <= ct_status;
			else if (ctl.chk_ends && !ends_in) status_q <= rcmc_pkg::RS_BAD;

			if (ctl.merge_start || ctl.out_start) node_q <= '0;
			else if (sweep_issue || ctl.load_node) node_q <= node_q + 1'b1;

			if (ctl.walk_start) edge_q <= '0;
			else if (wk_issue) edge_q <= edge_q + 1'b1;

			if (ctl.walk_start) begin
				cut_q <= '0;
			end else if (wk_v_s2 && (label_a != label_b) && (cut_q != rcmc_pkg::CUT_MAX)) begin
				cut_q <= cut_q + 1'b1;
			end
		end
	end

	// Result register: a new result may load in the cycle the previous one is taken.
	always_ff @(posedge clk) begin
		if (ctl.load_node) begin
			res_q.status <= rcmc_pkg::RS_OK;
			res_q.node_index <= node_q[NW-1:0];
			res_q.node_label <= label_a;
			res_q.sets_left <= set_total_q;
			res_q.cut_edges <= cut_q;
			res_q.last <= sts.out_last;
		end else if (ctl.load_single) begin
			res_q.status <= status_q;
			res_q.node_index <= '0;
			res_q.node_label <= '0;
			res_q.sets_left <= set_total_q;
			res_q.cut_edges <= '0;
			res_q.last <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load_node || ctl.load_single) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	assign sts.func = req_q.func;
	assign sts.ct_reject = (ct_status != rcmc_pkg::RS_OK);
	assign sts.ends_bad = !ends_in;
	assign sts.same_set = (label_a == label_b);
	assign sts.sweep_done = !(node_q < n) && !sw_v_s1;
	assign sts.walk_done = !(edge_q < edge_total_q) && !wk_v_s1 && !wk_v_s2;
	assign sts.out_free = !res_valid_q || !res_stall;
	assign sts.out_last = ((node_q + 1'b1) == n);

endmodule

// ===== src/random_contraction_min_cut.sv =====
// Top level of the random contraction minimum cut block.
// Depends on rcmc_pkg, rcmc_ctrl and rcmc_datapath.
//
// Channel   Handshake            Payload               Moves
// cmd       cmd_valid/cmd_stall  rcmc_pkg::req_t cmd   one request per item
// res       res_valid/res_stall  rcmc_pkg::rsp_t res   one result, or one per node on report
// cfg       cfg_valid/cfg_ready  cfg_data (7 bits)     nodes_in_use write
//
// Add and clear pass through the decode and finish states; a contraction that merges
// two sets ends with a relabelling sweep over the n nodes in use through the single
// write port of the label store. A report walks the edge store at one edge a cycle,
// so its first result loads once the walk is done, and the rest follow one per node,
// each read through the label store read port before it loads.
// Reset leaves every node in its own set through per-node valid bits; no clearing pass.
// Stalls on res hold the result register; a new request is taken once the previous
// request has loaded its last result, even while that result still waits.
module random_contraction_min_cut #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  rcmc_pkg::req_t             cmd,
	output logic                       res_valid,
	input  logic                       res_stall,
	output rcmc_pkg::rsp_t             res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rcmc_pkg::CNT_W-1:0] cfg_data
);

	rcmc_pkg::dp_cmd_t ctl;
	rcmc_pkg::dp_sts_t sts;

	rcmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rcmc_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.cfg_data  (cfg_data),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

// ===== src/rcmc_checker.sv =====
// Port-level checks for the random contraction minimum cut block, bound to its top level.
// Depends on rcmc_pkg and on the port list of random_contraction_min_cut.
module rcmc_checker #(
	parameter int MAX_NODES = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input logic           res_valid,
	input logic           res_stall,
	input rcmc_pkg::rsp_t res
);

	// A taken request always occupies the block for at least the following cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("request accepted on consecutive cycles");

	// Refused requests give a single closing result with no cut count.
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != rcmc_pkg::RS_OK) |-> res.last && (res.cut_edges == '0))
		else $error("error result is not a lone final result");

	// Contraction never goes below two sets nor above the node capacity.
	a_sets_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.sets_left >= rcmc_pkg::MIN_NODES)
			&& (res.sets_left <= rcmc_pkg::CNT_W'(MAX_NODES)))
		else $error("set count out of range");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

endmodule

bind random_contraction_min_cut rcmc_checker #(
	.MAX_NODES (MAX_NODES)
) u_rcmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
